@@ design/mrmd_pkg.sv @@
// Shared types, constants and codes for the memory region map decoder.
package mrmd_pkg;

   localparam int REGION_SLOTS = 8;
   localparam int ADDR_BITS   = 32;
   localparam int LEN_W       = ADDR_BITS + 1;
   localparam int EXT_W       = ADDR_BITS + 2;
   localparam int IDX_W       = $clog2(REGION_SLOTS);
   localparam int CNT_W       = $clog2(REGION_SLOTS + 1);
   localparam int KIND_W      = 2;
   localparam int RTYPE_W     = 2;
   localparam int STATUS_W    = 3;

   localparam int REQ_FIELDS_W = ADDR_BITS + LEN_W + RTYPE_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = STATUS_W + IDX_W + RTYPE_W + 1 + 1 + ADDR_BITS + CNT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   localparam logic [ADDR_BITS-1:0] ADDR_TOP = '1;

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_LOOKUP = 2'd2,
      KIND_NOP    = 2'd3
   } kind_type;

   typedef enum logic [RTYPE_W-1:0] {
      RTYPE_RAM  = 2'd0,
      RTYPE_ROM  = 2'd1,
      RTYPE_MMIO = 2'd2,
      RTYPE_RSVD = 2'd3
   } rtype_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 3'd0,
      STATUS_MISS     = 3'd1,
      STATUS_ZERO     = 3'd2,
      STATUS_OVERFLOW = 3'd3,
      STATUS_OVERLAP  = 3'd4,
      STATUS_FULL     = 3'd5
   } status_type;

   typedef struct packed {
      logic load;
      logic eval;
   } cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [IDX_W-1:0]     region_index;
      logic [RTYPE_W-1:0]   matched_type;
      logic                 host_backed;
      logic                 writable;
      logic [ADDR_BITS-1:0] offset;
      logic [CNT_W-1:0]     count_now;
   } result_type;

endpackage

@@ design/mrmd_datapath.sv @@
// Datapath: request register, region table, parallel range compare, result register.
module mrmd_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  mrmd_pkg::cmd_type                 cmd,
   input  logic [mrmd_pkg::KIND_W-1:0]       req_kind,
   input  logic [mrmd_pkg::ADDR_BITS-1:0]    req_address,
   input  logic [mrmd_pkg::LEN_W-1:0]        req_length,
   input  logic [mrmd_pkg::RTYPE_W-1:0]      req_region_type,
   output mrmd_pkg::result_type              result
);

   logic [mrmd_pkg::KIND_W-1:0]    kind_ff;
   logic [mrmd_pkg::ADDR_BITS-1:0] addr_ff;
   logic [mrmd_pkg::LEN_W-1:0]     len_ff;
   logic [mrmd_pkg::RTYPE_W-1:0]   rtype_ff;

   logic [mrmd_pkg::ADDR_BITS-1:0] base_ff [mrmd_pkg::REGION_SLOTS];
   logic [mrmd_pkg::ADDR_BITS-1:0] end_ff  [mrmd_pkg::REGION_SLOTS];
   logic [mrmd_pkg::RTYPE_W-1:0]   type_ff [mrmd_pkg::REGION_SLOTS];

   logic [mrmd_pkg::CNT_W-1:0]     count_ff;
   logic [mrmd_pkg::CNT_W-1:0]     count_in;
   mrmd_pkg::result_type           result_ff;
   mrmd_pkg::result_type           result_in;

   logic [mrmd_pkg::LEN_W-1:0]     len_eff;
   logic [mrmd_pkg::EXT_W-1:0]     look_end;
   logic [mrmd_pkg::EXT_W-1:0]     app_end;
   logic [mrmd_pkg::REGION_SLOTS-1:0] live;
   logic [mrmd_pkg::REGION_SLOTS-1:0] hit;
   logic [mrmd_pkg::REGION_SLOTS-1:0] ovl;
   logic [mrmd_pkg::IDX_W-1:0]     hit_idx;
   logic [mrmd_pkg::RTYPE_W-1:0]   app_type;
   logic                           app_ok;

   always_comb begin
      len_eff  = (len_ff == '0) ? mrmd_pkg::LEN_W'(1) : len_ff;
      look_end = mrmd_pkg::EXT_W'(addr_ff) + mrmd_pkg::EXT_W'(len_eff) - mrmd_pkg::EXT_W'(1);
      app_end  = mrmd_pkg::EXT_W'(addr_ff) + mrmd_pkg::EXT_W'(len_ff) - mrmd_pkg::EXT_W'(1);
      for (int j = 0; j < mrmd_pkg::REGION_SLOTS; j++) begin
         live[j] = mrmd_pkg::CNT_W'(j) < count_ff;
         hit[j]  = live[j] && (addr_ff >= base_ff[j])
                   && (look_end <= mrmd_pkg::EXT_W'(end_ff[j]));
         ovl[j]  = live[j] && (mrmd_pkg::EXT_W'(addr_ff) <= mrmd_pkg::EXT_W'(end_ff[j]))
                   && (app_end >= mrmd_pkg::EXT_W'(base_ff[j]));
      end
      hit_idx = '0;
      for (int j = mrmd_pkg::REGION_SLOTS - 1; j >= 0; j--) begin
         if (hit[j]) begin
            hit_idx = mrmd_pkg::IDX_W'(j);
         end
      end
      app_type = (rtype_ff == mrmd_pkg::RTYPE_RSVD) ? mrmd_pkg::RTYPE_MMIO : rtype_ff;
   end

   always_comb begin
      result_in           = '0;
      app_ok              = 1'b0;
      count_in            = count_ff;
      unique case (mrmd_pkg::kind_type'(kind_ff))
         mrmd_pkg::KIND_CLEAR: begin
            count_in = '0;
         end
         mrmd_pkg::KIND_APPEND: begin
            priority if (len_ff == '0) begin
               result_in.status = mrmd_pkg::STATUS_ZERO;
            end else if (app_end > mrmd_pkg::EXT_W'(mrmd_pkg::ADDR_TOP)) begin
               result_in.status = mrmd_pkg::STATUS_OVERFLOW;
            end else if (|ovl) begin
               result_in.status = mrmd_pkg::STATUS_OVERLAP;
            end else if (count_ff >= mrmd_pkg::CNT_W'(mrmd_pkg::REGION_SLOTS)) begin
               result_in.status = mrmd_pkg::STATUS_FULL;
            end else begin
               result_in.status       = mrmd_pkg::STATUS_OK;
               result_in.region_index = count_ff[mrmd_pkg::IDX_W-1:0];
               app_ok                 = 1'b1;
               count_in               = count_ff + mrmd_pkg::CNT_W'(1);
            end
         end
         mrmd_pkg::KIND_LOOKUP: begin
            if (|hit) begin
               result_in.status       = mrmd_pkg::STATUS_OK;
               result_in.region_index = hit_idx;
               result_in.matched_type = type_ff[hit_idx];
               result_in.host_backed  = type_ff[hit_idx] != mrmd_pkg::RTYPE_MMIO;
               result_in.writable     = type_ff[hit_idx] == mrmd_pkg::RTYPE_RAM;
               result_in.offset       = addr_ff - base_ff[hit_idx];
            end else begin
               result_in.status = mrmd_pkg::STATUS_MISS;
            end
         end
         mrmd_pkg::KIND_NOP: begin
            result_in.status = mrmd_pkg::STATUS_OK;
         end
         default: begin
            result_in.status = mrmd_pkg::STATUS_OK;
         end
      endcase
      result_in.count_now = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.eval) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         addr_ff  <= req_address;
         len_ff   <= req_length;
         rtype_ff <= req_region_type;
      end
      if (cmd.eval) begin
         result_ff <= result_in;
      end
      if (cmd.eval && app_ok) begin
         base_ff[count_ff[mrmd_pkg::IDX_W-1:0]] <= addr_ff;
         end_ff[count_ff[mrmd_pkg::IDX_W-1:0]]  <= app_end[mrmd_pkg::ADDR_BITS-1:0];
         type_ff[count_ff[mrmd_pkg::IDX_W-1:0]] <= app_type;
      end
   end

   assign result = result_ff;

endmodule

@@ design/mrmd_ctrl.sv @@
// Controller: request holding state machine and result valid tracking.
module mrmd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output mrmd_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_HOLD = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      out_valid_ff;
   logic      out_valid_in;
   logic      eval;
   logic      accept;

   always_comb begin
      eval         = (state_ff == ST_HOLD) && (!out_valid_ff || rsp_tready);
      req_tready   = (state_ff == ST_IDLE) || eval;
      accept       = req_tvalid && req_tready;
      out_valid_in = eval ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      unique case (state_ff)
         ST_IDLE: begin
            state_in = accept ? ST_HOLD : ST_IDLE;
         end
         ST_HOLD: begin
            state_in = (eval && !accept) ? ST_IDLE : ST_HOLD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign cmd.load   = accept;
   assign cmd.eval   = eval;
   assign rsp_tvalid = out_valid_ff;

endmodule

@@ design/memory_region_map_decoder.sv @@
// A request is captured in the request register and evaluated into the result register, which drives the response.
// Throughput: one request per cycle while the result side keeps up; the region table
// compare of all eight entries in parallel sets the evaluate cycle.
// A stalled result holds in the output register while one further request waits.
// Reset (synchronous, active high) empties the table and drops any held request or result.
// Top level: memory region map decoder.
module memory_region_map_decoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // address [31:0], length [64:32], region_type [66:65], zero fill above
   input  logic [mrmd_pkg::REQ_DATA_W-1:0]    req_tdata,
   // kind [1:0]
   input  logic [mrmd_pkg::KIND_W-1:0]        req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // status [2:0], region_index [5:3], matched_type [7:6], host_backed [8],
   // writable [9], offset [41:10], count_now [45:42], zero fill above
   output logic [mrmd_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int LEN_LO = mrmd_pkg::ADDR_BITS;
   localparam int RT_LO  = mrmd_pkg::ADDR_BITS + mrmd_pkg::LEN_W;

   mrmd_pkg::cmd_type    cmd;
   mrmd_pkg::result_type result;

   mrmd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   mrmd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_kind        (req_tuser),
      .req_address     (req_tdata[mrmd_pkg::ADDR_BITS-1:0]),
      .req_length      (req_tdata[LEN_LO +: mrmd_pkg::LEN_W]),
      .req_region_type (req_tdata[RT_LO +: mrmd_pkg::RTYPE_W]),
      .result          (result)
   );

   assign rsp_tdata = {{mrmd_pkg::RSP_PAD_W{1'b0}}, result.count_now, result.offset,
                       result.writable, result.host_backed, result.matched_type,
                       result.region_index, result.status};

endmodule

@@ design/mrmd_checker.sv @@
// Port-level checker for the memory region map decoder, with its bind.
module mrmd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mrmd_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[45:42] <= 4'(mrmd_pkg::REGION_SLOTS)
                     && rsp_tdata[2:0] <= 3'(mrmd_pkg::STATUS_FULL))
      else $error("region count or status out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9] |-> rsp_tdata[8] && rsp_tdata[2:0] == 3'(mrmd_pkg::STATUS_OK))
      else $error("writable region not host backed or not a hit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != 3'(mrmd_pkg::STATUS_OK) |-> rsp_tdata[41:3] == '0)
      else $error("failed request carries region fields");

endmodule

bind memory_region_map_decoder mrmd_checker u_mrmd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ test/testbench.sv @@
// Self-checking testbench for the memory region map decoder: random streams, inline predictor.
`timescale 1ns / 1ps

module testbench;

   localparam int          CYCLE_LIMIT = 400000;
   localparam int          QUIET_TAIL  = 150;
   localparam int          TOTAL_REQS  = 1925;
   localparam int unsigned SLOT_SPAN   = 32'h1000_0000;

   typedef struct {
      logic [mrmd_pkg::KIND_W-1:0]    kind;
      logic [mrmd_pkg::ADDR_BITS-1:0] addr;
      logic [mrmd_pkg::LEN_W-1:0]     len;
      logic [mrmd_pkg::RTYPE_W-1:0]   rtype;
   } map_request_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [mrmd_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [mrmd_pkg::KIND_W-1:0]     req_tuser  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [mrmd_pkg::RSP_DATA_W-1:0] rsp_tdata;

   map_request_type      map_requests[$];
   mrmd_pkg::result_type decoded_results[$];
   map_request_type      on_bus;
   mrmd_pkg::result_type want_rsp;
   int                   send_gap    = 0;
   int                   recv_stall  = 0;
   int                   error_count = 0;
   int                   cycle_count = 0;

   // predictor copy of the region table
   logic [mrmd_pkg::ADDR_BITS-1:0] map_base[mrmd_pkg::REGION_SLOTS];
   logic [mrmd_pkg::LEN_W-1:0]     map_size[mrmd_pkg::REGION_SLOTS];
   logic [mrmd_pkg::RTYPE_W-1:0]   map_type[mrmd_pkg::REGION_SLOTS];
   int                             map_count = 0;

   // regions planned for the current random session
   longint unsigned sess_base[10];
   longint unsigned sess_size[10];
   int unsigned     sess_n = 1;

   memory_region_map_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic mrmd_pkg::result_type decode_request(map_request_type r);
      mrmd_pkg::result_type res;
      logic [63:0]          right;
      logic [63:0]          last_byte;
      logic [63:0]          len;
      logic                 clash;
      logic                 found;
      int                   j;
      res = '0;
      case (r.kind)
         mrmd_pkg::KIND_CLEAR: begin
            map_count = 0;
         end
         mrmd_pkg::KIND_APPEND: begin
            right = {32'b0, r.addr} + {31'b0, r.len} - 64'd1;
            if (r.len == '0) begin
               res.status = mrmd_pkg::STATUS_ZERO;
            end else if (right > {32'b0, mrmd_pkg::ADDR_TOP}) begin
               res.status = mrmd_pkg::STATUS_OVERFLOW;
            end else begin
               clash = 1'b0;
               for (j = 0; j < map_count; j++) begin
                  if ({32'b0, r.addr} <= {32'b0, map_base[j]} + {31'b0, map_size[j]} - 64'd1 &&
                      right >= {32'b0, map_base[j]})
                     clash = 1'b1;
               end
               if (clash) begin
                  res.status = mrmd_pkg::STATUS_OVERLAP;
               end else if (map_count >= mrmd_pkg::REGION_SLOTS) begin
                  res.status = mrmd_pkg::STATUS_FULL;
               end else begin
                  map_base[map_count] = r.addr;
                  map_size[map_count] = r.len;
                  map_type[map_count] = (r.rtype == mrmd_pkg::RTYPE_RSVD) ?
                                        mrmd_pkg::RTYPE_MMIO : r.rtype;
                  res.status = mrmd_pkg::STATUS_OK;
                  res.region_index = map_count[mrmd_pkg::IDX_W-1:0];
                  map_count++;
               end
            end
         end
         mrmd_pkg::KIND_LOOKUP: begin
            len = (r.len == '0) ? 64'd1 : {31'b0, r.len};
            last_byte = {32'b0, r.addr} + len - 64'd1;
            found = 1'b0;
            res.status = mrmd_pkg::STATUS_MISS;
            for (j = 0; j < map_count; j++) begin
               if (!found && r.addr >= map_base[j] &&
                   last_byte < {32'b0, map_base[j]} + {31'b0, map_size[j]}) begin
                  found = 1'b1;
                  res.status = mrmd_pkg::STATUS_OK;
                  res.region_index = j[mrmd_pkg::IDX_W-1:0];
                  res.matched_type = map_type[j];
                  res.host_backed = (map_type[j] != mrmd_pkg::RTYPE_MMIO);
                  res.writable = (map_type[j] == mrmd_pkg::RTYPE_RAM);
                  res.offset = r.addr - map_base[j];
               end
            end
         end
         default: begin
         end
      endcase
      res.count_now = map_count[mrmd_pkg::CNT_W-1:0];
      return res;
   endfunction

   task automatic push_item(logic [mrmd_pkg::KIND_W-1:0] kind,
                            logic [mrmd_pkg::ADDR_BITS-1:0] addr,
                            logic [mrmd_pkg::LEN_W-1:0] len,
                            logic [mrmd_pkg::RTYPE_W-1:0] rtype);
      map_request_type item;
      item.kind  = kind;
      item.addr  = addr;
      item.len   = len;
      item.rtype = rtype;
      map_requests.push_back(item);
   endtask

   function automatic logic [mrmd_pkg::LEN_W-1:0] random_len();
      case ($urandom_range(0, 3))
         0: return mrmd_pkg::LEN_W'($urandom_range(0, 16));
         1: return mrmd_pkg::LEN_W'($urandom);
         2: return 33'h1_0000_0000;
         default: return mrmd_pkg::LEN_W'($urandom_range(0, 4096));
      endcase
   endfunction

   // lookup aimed at one of the planned regions, inside, at its edges or just outside it
   task automatic aim_lookup();
      int unsigned     j;
      longint unsigned base;
      longint unsigned size;
      longint unsigned addr;
      longint unsigned rem;
      longint unsigned len;
      j = $urandom_range(0, sess_n - 1);
      base = sess_base[j];
      size = sess_size[j];
      addr = base + $urandom_range(0, 32'(size - 1));
      rem = base + size - addr;
      case ($urandom_range(0, 5))
         0: len = 0;
         1: len = 1;
         2: len = 64'($urandom_range(1, 32'(rem)));
         3: len = rem;
         4: len = rem + 1;
         default: begin
            addr = (base - 1) & 64'hFFFF_FFFF;
            len = 64'($urandom_range(1, 4));
         end
      endcase
      push_item(mrmd_pkg::KIND_LOOKUP, addr[mrmd_pkg::ADDR_BITS-1:0],
                len[mrmd_pkg::LEN_W-1:0], 2'($urandom_range(0, 3)));
   endtask

   task automatic add_noise();
      int unsigned     j;
      longint unsigned addr;
      longint unsigned len;
      case ($urandom_range(0, 5))
         0: push_item(mrmd_pkg::KIND_LOOKUP, $urandom, random_len(), 2'($urandom_range(0, 3)));
         1: push_item(mrmd_pkg::KIND_APPEND, $urandom, '0, 2'($urandom_range(0, 3)));
         2: begin
            addr = 64'hFFFF_FFFF - $urandom_range(0, 4095);
            len = 64'h1_0000_0000 - addr + $urandom_range(1, 4096);
            push_item(mrmd_pkg::KIND_APPEND, addr[mrmd_pkg::ADDR_BITS-1:0],
                      len[mrmd_pkg::LEN_W-1:0], 2'($urandom_range(0, 3)));
         end
         3: begin
            j = $urandom_range(0, sess_n - 1);
            addr = sess_base[j] + $urandom_range(0, 32'(sess_size[j] - 1));
            len = 64'($urandom_range(1, 4096));
            push_item(mrmd_pkg::KIND_APPEND, addr[mrmd_pkg::ADDR_BITS-1:0],
                      len[mrmd_pkg::LEN_W-1:0], 2'($urandom_range(0, 3)));
         end
         4: push_item(mrmd_pkg::KIND_NOP, $urandom, random_len(), 2'($urandom_range(0, 3)));
         default: push_item(mrmd_pkg::KIND_APPEND, $urandom, random_len(),
                            2'($urandom_range(0, 3)));
      endcase
   endtask

   // clear, fill with disjoint regions in shuffled 256 MiB slots, then probe
   task automatic build_session();
      int unsigned     slot_order[16];
      int unsigned     i;
      int unsigned     j;
      int unsigned     tmp;
      int unsigned     n;
      int unsigned     m;
      int unsigned     size;
      longint unsigned lo;
      for (i = 0; i < 16; i++)
         slot_order[i] = i;
      for (i = 15; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = slot_order[i];
         slot_order[i] = slot_order[j];
         slot_order[j] = tmp;
      end
      push_item(mrmd_pkg::KIND_CLEAR, $urandom, random_len(), 2'($urandom_range(0, 3)));
      n = $urandom_range(1, 10);
      sess_n = n;
      for (i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0: size = $urandom_range(1, 64);
            1: size = $urandom_range(1, 65536);
            2: size = $urandom_range(1, SLOT_SPAN);
            default: size = SLOT_SPAN;
         endcase
         lo = longint'(slot_order[i]) * SLOT_SPAN;
         case ($urandom_range(0, 2))
            0: lo = lo;
            1: lo = lo + SLOT_SPAN - size;
            default: lo = lo + $urandom_range(0, SLOT_SPAN - size);
         endcase
         sess_base[i] = lo;
         sess_size[i] = size;
         push_item(mrmd_pkg::KIND_APPEND, lo[mrmd_pkg::ADDR_BITS-1:0],
                   mrmd_pkg::LEN_W'(size), 2'($urandom_range(0, 3)));
         if ($urandom_range(0, 2) == 0)
            aim_lookup();
      end
      m = $urandom_range(6, 24);
      for (i = 0; i < m; i++) begin
         if ($urandom_range(0, 4) != 0)
            aim_lookup();
         else
            add_noise();
      end
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            decoded_results.push_back(decode_request(on_bus));
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (map_requests.size() > 0) begin
               on_bus = map_requests.pop_front();
               req_tdata <= {{(mrmd_pkg::REQ_DATA_W - mrmd_pkg::REQ_FIELDS_W){1'b0}},
                             on_bus.rtype, on_bus.len, on_bus.addr};
               req_tuser <= on_bus.kind;
               req_tvalid <= 1'b1;
               if (map_requests.size() >= QUIET_TAIL && $urandom_range(0, 3) == 0)
                  send_gap = $urandom_range(1, 8);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_results.size() == 0) begin
               $display("%0t: unexpected response, expected none actual %0h", $time, rsp_tdata);
               error_count++;
            end else begin
               want_rsp = decoded_results.pop_front();
               check_field("status", want_rsp.status, rsp_tdata[2:0]);
               check_field("region_index", want_rsp.region_index, rsp_tdata[5:3]);
               check_field("matched_type", want_rsp.matched_type, rsp_tdata[7:6]);
               check_field("host_backed", want_rsp.host_backed, rsp_tdata[8]);
               check_field("writable", want_rsp.writable, rsp_tdata[9]);
               check_field("offset", want_rsp.offset, rsp_tdata[41:10]);
               check_field("count_now", want_rsp.count_now, rsp_tdata[45:42]);
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (map_requests.size() >= QUIET_TAIL && $urandom_range(0, 4) == 0)
               recv_stall = $urandom_range(1, 8);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : stimulus
      int k;
      // empty table, size and range checks against a whole-space region
      push_item(mrmd_pkg::KIND_LOOKUP, 32'h0, 33'h0, mrmd_pkg::RTYPE_RAM);
      push_item(mrmd_pkg::KIND_APPEND, 32'h0, 33'h0, mrmd_pkg::RTYPE_RAM);
      push_item(mrmd_pkg::KIND_APPEND, 32'hFFFF_FFFF, 33'h2, mrmd_pkg::RTYPE_ROM);
      push_item(mrmd_pkg::KIND_APPEND, 32'h0, 33'h1_0000_0000, mrmd_pkg::RTYPE_RAM);
      push_item(mrmd_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 33'h1, mrmd_pkg::RTYPE_RAM);
      push_item(mrmd_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 33'h2, mrmd_pkg::RTYPE_RAM);
      push_item(mrmd_pkg::KIND_LOOKUP, 32'h0, 33'h1_0000_0000, mrmd_pkg::RTYPE_RAM);
      push_item(mrmd_pkg::KIND_APPEND, 32'h1000, 33'h10, mrmd_pkg::RTYPE_MMIO);
      push_item(mrmd_pkg::KIND_NOP, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF, mrmd_pkg::RTYPE_RSVD);
      push_item(mrmd_pkg::KIND_CLEAR, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF, mrmd_pkg::RTYPE_RSVD);
      // fill the table, last region ends at the top of the space
      for (k = 0; k < 7; k++)
         push_item(mrmd_pkg::KIND_APPEND, 32'(k) << 28, 33'h100, 2'(k % 4));
      push_item(mrmd_pkg::KIND_APPEND, 32'hFFFF_FF00, 33'h100, mrmd_pkg::RTYPE_RSVD);
      push_item(mrmd_pkg::KIND_APPEND, 32'h8000_0000, 33'h1, mrmd_pkg::RTYPE_RAM);
      push_item(mrmd_pkg::KIND_APPEND, 32'h1000_0000, 33'h1, mrmd_pkg::RTYPE_RAM);
      push_item(mrmd_pkg::KIND_LOOKUP, 32'h1000_0080, 33'h80, mrmd_pkg::RTYPE_RAM);
      push_item(mrmd_pkg::KIND_LOOKUP, 32'h2000_00FF, 33'h2, mrmd_pkg::RTYPE_RAM);
      push_item(mrmd_pkg::KIND_LOOKUP, 32'h3000_0000, 33'h0, mrmd_pkg::RTYPE_RAM);
      push_item(mrmd_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 33'h0, mrmd_pkg::RTYPE_RAM);
      push_item(mrmd_pkg::KIND_LOOKUP, 32'hFFFF_FF00, 33'h1_0000_0000, mrmd_pkg::RTYPE_RAM);
      while (map_requests.size() < TOTAL_REQS)
         build_session();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (map_requests.size() != 0 || req_tvalid)
         @(posedge clock);
      while (decoded_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

@@ filelist.f @@
design/mrmd_pkg.sv
design/mrmd_datapath.sv
design/mrmd_ctrl.sv
design/memory_region_map_decoder.sv
design/mrmd_checker.sv
test/testbench.sv
